### src/vdi_pkg.sv
`default_nettype none
package vdi_pkg;

	localparam int NCOMP = 10;
	localparam int UV_LAYERS = 2;
	localparam int IN_W = 368;
	localparam int OUT_W = 208;
	localparam int STORE_W = 32 * NCOMP + 32;
	localparam logic [31:0] TOL_RESET = 32'd110;
	localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;

	localparam logic [1:0] CFG_UV_LAYERS = 2'd0;
	localparam logic [1:0] CFG_COLORS = 2'd1;
	localparam logic [1:0] CFG_TOL = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_STORE,
		ST_SQ,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load_in;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### src/vdi_ctrl.sv
`default_nettype none
module vdi_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	output vdi_pkg::cmd_t     cmd,
	input  wire vdi_pkg::sts_t sts
);
	import vdi_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_MAP;
				end
			end
			ST_MAP: state_d = ST_STORE;
			ST_STORE: state_d = ST_SQ;
			ST_SQ: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule
`default_nettype wire

### src/vdi_datapath.sv
`default_nettype none
module vdi_datapath #(
	parameter int MAX_VERTICES = 4096,
	parameter int SOURCE_INDEX_RANGE = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_addr,
	input  wire logic [31:0]                cfg_wdata,
	input  wire logic [vdi_pkg::IN_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [vdi_pkg::OUT_W-1:0]       m_tdata,
	output logic [1:0]                      m_tuser,
	input  wire vdi_pkg::cmd_t              cmd,
	output vdi_pkg::sts_t                   sts
);
	import vdi_pkg::*;

	localparam int SW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int MW = (SOURCE_INDEX_RANGE > 1) ? $clog2(SOURCE_INDEX_RANGE) : 1;
	localparam logic [16:0] SRC_RANGE = 17'(SOURCE_INDEX_RANGE);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_VERTICES);
	localparam logic [MW-1:0] CLR_LAST = MW'(SOURCE_INDEX_RANGE - 1);

	logic [1:0]  uv_layers_q;
	logic        colors_q;
	logic [31:0] tol_q;

	logic [11:0]             src_q;
	logic [31:0]             comp_q [NCOMP];
	logic [31:0]             color_q;

	logic [SW:0]             map_mem [SOURCE_INDEX_RANGE];
	logic [SW:0]             map_q;
	logic [STORE_W-1:0]      store_mem [MAX_VERTICES];
	logic [STORE_W-1:0]      store_q;
	logic [MW-1:0]           clr_cnt_q;
	logic [CW-1:0]           count_q;
	logic signed [31:0]      box_min_q [3];
	logic signed [31:0]      box_max_q [3];

	logic [31:0]             sq_q [NCOMP];
	logic [NCOMP-1:0]        near_q;
	logic                    col_eq_q;

	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;
	logic [1:0]              out_user_q;

	logic [16:0]             src_ext;
	logic                    in_range;
	logic [MW-1:0]           map_idx;
	logic [STORE_W-1:0]      store_wdata;
	logic                    map_we;
	logic [MW-1:0]           map_waddr;
	logic [SW:0]             map_wdata;
	logic signed [32:0]      diff [NCOMP];
	logic [32:0]             adiff [NCOMP];
	logic [33:0]             sum_pos, sum_nrm, sum_uv0, sum_uv1;
	logic [1:0]              layers;
	logic                    match, hit, full, append;
	logic [SW-1:0]           slot;
	logic [31:0]             slot_wide;
	logic signed [31:0]      min_d [3];
	logic signed [31:0]      max_d [3];
	logic signed [31:0]      pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uv_layers_q <= 2'd0;
			colors_q <= 1'b0;
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_UV_LAYERS: uv_layers_q <= cfg_wdata[1:0];
				CFG_COLORS: colors_q <= cfg_wdata[0];
				CFG_TOL: tol_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			src_q <= s_tdata[11:0];
			for (int i = 0; i < 6; i++) comp_q[i] <= s_tdata[12 + 32*i +: 32];
			color_q <= s_tdata[204 +: 32];
			for (int i = 0; i < 4; i++) comp_q[6 + i] <= s_tdata[236 + 32*i +: 32];
		end
	end

	assign src_ext = 17'(src_q);
	assign in_range = src_ext < SRC_RANGE;
	assign map_idx = src_ext[MW-1:0];

	// source index map
	assign map_we = cmd.clr_step || (cmd.commit && append && in_range);
	assign map_waddr = cmd.clr_step ? clr_cnt_q : map_idx;
	assign map_wdata = cmd.clr_step ? '0 : {1'b1, count_q[SW-1:0]};

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		map_q <= map_mem[map_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + MW'(1);
		end
	end

	assign sts.clr_last = clr_cnt_q == CLR_LAST;

	// vertex store
	always_comb begin
		store_wdata = '0;
		for (int i = 0; i < NCOMP; i++) store_wdata[32*i +: 32] = comp_q[i];
		store_wdata[32*NCOMP +: 32] = color_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && append) store_mem[count_q[SW-1:0]] <= store_wdata;
		store_q <= store_mem[map_q[SW-1:0]];
	end

	// squared differences
	always_comb begin
		for (int i = 0; i < NCOMP; i++) begin
			diff[i] = $signed({store_q[32*i + 31], store_q[32*i +: 32]})
				- $signed({comp_q[i][31], comp_q[i]});
			adiff[i] = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NCOMP; i++) begin
			sq_q[i] <= adiff[i][15:0] * adiff[i][15:0];
			near_q[i] <= adiff[i][32:16] == '0;
		end
		col_eq_q <= store_q[32*NCOMP +: 32] == color_q;
	end

	// match decision
	assign layers = (uv_layers_q > 2'(UV_LAYERS)) ? 2'(UV_LAYERS) : uv_layers_q;
	assign sum_pos = 34'(sq_q[0]) + 34'(sq_q[1]) + 34'(sq_q[2]);
	assign sum_nrm = 34'(sq_q[3]) + 34'(sq_q[4]) + 34'(sq_q[5]);
	assign sum_uv0 = 34'(sq_q[6]) + 34'(sq_q[7]);
	assign sum_uv1 = 34'(sq_q[8]) + 34'(sq_q[9]);

	always_comb begin
		match = (&near_q[2:0]) && (sum_pos < 34'(tol_q))
			&& (&near_q[5:3]) && (sum_nrm < 34'(tol_q))
			&& (!colors_q || col_eq_q);
		if (layers >= 2'd1)
			match = match && (&near_q[7:6]) && (sum_uv0 < 34'(tol_q));
		if (layers >= 2'd2)
			match = match && (&near_q[9:8]) && (sum_uv1 < 34'(tol_q));
	end

	assign hit = in_range && map_q[SW] && (CW'(map_q[SW-1:0]) < count_q) && match;
	assign full = count_q == FULL_COUNT;
	assign append = !hit && !full;
	assign slot = hit ? map_q[SW-1:0] : (append ? count_q[SW-1:0] : '0);
	assign slot_wide = 32'(slot);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos = $signed(comp_q[i]);
			min_d[i] = box_min_q[i];
			max_d[i] = box_max_q[i];
			if (append && pos < box_min_q[i]) min_d[i] = pos;
			if (append && pos > box_max_q[i]) max_d[i] = pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= POS_MAX;
				box_max_q[i] <= NEG_MAX;
			end
		end else if (cmd.commit) begin
			if (append) count_q <= count_q + CW'(1);
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= min_d[i];
				box_max_q[i] <= max_d[i];
			end
		end
	end

	// output register
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= {4'd0, max_d[2], max_d[1], max_d[0],
				min_d[2], min_d[1], min_d[0], slot_wide[11:0]};
			out_user_q <= {full && !hit, append};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

endmodule
`default_nettype wire

### src/vertex_dedup_indexer.sv
// vertex welding lookup for an index buffer builder
// s channel: one word per vertex; s_tdata from bit 0 up holds source_index,
//   pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, vertex_color, uv0_u, uv0_v,
//   uv1_u, uv1_v, then four zero bits
// m channel: one word per vertex with the slot to put in the index buffer,
//   whether it was appended or the store overflowed, and the running box
// cfg port: cfg_we writes cfg_wdata to register cfg_addr (0 uv layer count,
//   1 colors enabled, 2 match tolerance squared); the user must write only
//   while idle, which the block itself does not enforce
// each word passes the accept, the map read, the dependent store read, the
//   squaring stage and the decision with write-back before the next is taken
// reset: after arst_n the map valid marks are cleared in a pass over all
//   SOURCE_INDEX_RANGE entries, during which s_tready stays low
// a stalled receiver holds the result; the block may take one more word,
//   then waits in its decision step until the output register frees up
`default_nettype none
module vertex_dedup_indexer #(
	parameter int MAX_VERTICES = 4096,
	parameter int SOURCE_INDEX_RANGE = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_addr,
	input  wire logic [31:0]              cfg_wdata,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// source_index, pos_x..z, nrm_x..z, vertex_color, uv0_u, uv0_v, uv1_u, uv1_v
	input  wire logic [vdi_pkg::IN_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// vertex_slot, box_min_x..z, box_max_x..z
	output logic [vdi_pkg::OUT_W-1:0]     m_tdata,
	// is_new, overflow
	output logic [1:0]                    m_tuser
);
	import vdi_pkg::*;

	cmd_t cmd;
	sts_t sts;

	vdi_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd(cmd),
		.sts(sts)
	);

	vdi_datapath #(
		.MAX_VERTICES(MAX_VERTICES),
		.SOURCE_INDEX_RANGE(SOURCE_INDEX_RANGE)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cmd(cmd),
		.sts(sts)
	);

endmodule
`default_nettype wire

### src/vdi_checker.sv
`default_nettype none
module vdi_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_tvalid,
	input wire logic                     s_tready,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [vdi_pkg::OUT_W-1:0] m_tdata,
	input wire logic [1:0]               m_tuser
);
	import vdi_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while busy");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("appended and overflow together");

	a_overflow_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[11:0] == 12'd0)
		else $error("overflow result with nonzero slot");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);
`default_nettype wire

### tb/sv/vertex_dedup_indexer_tb.sv
`default_nettype none
module vertex_dedup_indexer_tb;
	import vdi_pkg::*;

	typedef logic [11:0][31:0] vtx_t;
	typedef struct packed {
		logic [11:0]      slot;
		logic             is_new;
		logic             ovf;
		logic [2:0][31:0] bmin;
		logic [2:0][31:0] bmax;
	} weld_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = CFG_UV_LAYERS;
	logic [31:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	vertex_dedup_indexer u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// welding model state
	logic [11:0] slot_of [4096];
	bit          slot_ok [4096];
	vtx_t        welded [4096];
	int          n_welded;
	logic signed [31:0] box_lo [3];
	logic signed [31:0] box_hi [3];
	logic [1:0]  uv_layers;
	logic        color_eq;
	logic [31:0] tol_sq;

	vtx_t  pending_vtx [$];
	weld_t expected_welds [$];
	int    send_idle_pct, recv_idle_pct;
	bit    took;
	int    errors, checked, n_new, n_ovf, n_reuse;

	// generator memory of the last vertex sent per source index
	vtx_t  last_sent [4096];
	bit    sent_once [4096];

	initial forever #5 clk = ~clk;

	function automatic bit near_sq(vtx_t a, vtx_t b, int first, int n);
		longint d;
		longint unsigned s;
		s = 0;
		for (int i = first; i < first + n; i++) begin
			d = longint'($signed(a[i])) - longint'($signed(b[i]));
			if (d < 0) d = -d;
			if (d >= 65536) return 1'b0;
			s += longint'(d * d);
		end
		return s < {32'd0, tol_sq};
	endfunction

	function automatic weld_t weld_vertex(vtx_t v);
		weld_t r;
		logic [11:0] src;
		logic [11:0] sp;
		int layers;
		bit hit;
		src = v[0][11:0];
		hit = 1'b0;
		layers = (uv_layers > UV_LAYERS) ? UV_LAYERS : uv_layers;
		r = '0;
		if (slot_ok[src]) begin
			sp = slot_of[src];
			if (sp < n_welded && near_sq(welded[sp], v, 1, 3) && near_sq(welded[sp], v, 4, 3)
					&& (!color_eq || welded[sp][7] == v[7])) begin
				hit = 1'b1;
				for (int l = 0; l < layers; l++)
					if (!near_sq(welded[sp], v, 8 + 2 * l, 2)) hit = 1'b0;
			end
			if (hit) r.slot = sp;
		end
		if (!hit) begin
			if (n_welded >= 4096) begin
				r.ovf = 1'b1;
			end else begin
				r.slot = n_welded[11:0];
				r.is_new = 1'b1;
				welded[n_welded] = v;
				for (int i = 0; i < 3; i++) begin
					if ($signed(v[1 + i]) < box_lo[i]) box_lo[i] = v[1 + i];
					if ($signed(v[1 + i]) > box_hi[i]) box_hi[i] = v[1 + i];
				end
				slot_of[src] = n_welded[11:0];
				slot_ok[src] = 1'b1;
				n_welded++;
			end
		end
		for (int i = 0; i < 3; i++) begin
			r.bmin[i] = box_lo[i];
			r.bmax[i] = box_hi[i];
		end
		return r;
	endfunction

	function automatic logic [IN_W-1:0] pack_vtx(vtx_t v);
		logic [IN_W-1:0] t;
		t = '0;
		t[11:0] = v[0][11:0];
		for (int i = 1; i < 12; i++) t[12 + 32 * (i - 1) +: 32] = v[i];
		return t;
	endfunction

	// driver
	always @(negedge clk) begin
		if (!s_tvalid || took) begin
			if (pending_vtx.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pack_vtx(pending_vtx.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor and predictor
	always @(posedge clk) begin
		vtx_t v;
		weld_t e, a;
		took <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			v[0] = {20'd0, s_tdata[11:0]};
			for (int i = 1; i < 12; i++) v[i] = s_tdata[12 + 32 * (i - 1) +: 32];
			expected_welds.insert(expected_welds.size(), weld_vertex(v));
		end
		if (m_tvalid && m_tready) begin
			a.slot = m_tdata[11:0];
			a.is_new = m_tuser[0];
			a.ovf = m_tuser[1];
			for (int i = 0; i < 3; i++) begin
				a.bmin[i] = m_tdata[12 + 32 * i +: 32];
				a.bmax[i] = m_tdata[108 + 32 * i +: 32];
			end
			checked++;
			if (expected_welds.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: %h", a);
			end else begin
				e = expected_welds.pop_front();
				if (a !== e) begin
					errors++;
					if (errors <= 10)
						$display("mismatch word %0d: slot %0d/%0d new %b/%b ovf %b/%b box %h/%h",
							checked, e.slot, a.slot, e.is_new, a.is_new, e.ovf, a.ovf,
							{e.bmin, e.bmax}, {a.bmin, a.bmax});
				end
				n_new += e.is_new;
				n_ovf += e.ovf;
				n_reuse += !e.is_new && !e.ovf;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_UV_LAYERS) uv_layers = val[1:0];
		else if (idx == CFG_COLORS) color_eq = val[0];
		else tol_sq = val;
	endtask

	task automatic drain();
		while (pending_vtx.size() > 0 || s_tvalid || expected_welds.size() > 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send(vtx_t v);
		pending_vtx.insert(pending_vtx.size(), v);
		last_sent[v[0][11:0]] = v;
		sent_once[v[0][11:0]] = 1'b1;
	endtask

	function automatic logic [31:0] rnd32();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic vtx_t random_vtx();
		vtx_t v;
		int src;
		int k;
		k = $urandom_range(9);
		if (k < 7) src = $urandom_range(63);
		else src = $urandom_range(4095);
		if (k < 6 && sent_once[src]) begin
			v = last_sent[src];
			// small jitter so the tolerance test sits near its edge
			for (int i = 1; i < 12; i++)
				if (i != 7 && $urandom_range(3) == 0) v[i] = v[i] + $urandom_range(0, 16) - 8;
			if ($urandom_range(7) == 0) v[7] = $urandom;
			if ($urandom_range(15) == 0) v[1 + $urandom_range(10)] = $urandom;
		end else begin
			v[0] = src;
			for (int i = 1; i < 12; i++) v[i] = rnd32();
		end
		return v;
	endfunction

	initial begin
		vtx_t v, b;
		for (int i = 0; i < 4096; i++) begin
			slot_ok[i] = 1'b0;
			sent_once[i] = 1'b0;
		end
		n_welded = 0;
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = POS_MAX;
			box_hi[i] = NEG_MAX;
		end
		uv_layers = 2'd0;
		color_eq = 1'b0;
		tol_sq = TOL_RESET;
		errors = 0; checked = 0; n_new = 0; n_ovf = 0; n_reuse = 0;
		send_idle_pct = 26;
		recv_idle_pct = 72;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, exact repeat, tolerance edges, color and uv handling
		b[0] = 0;
		for (int i = 1; i < 12; i++) b[i] = 32'h7fff_ffff;
		send(b);
		send(b);
		b[0] = 4095;
		for (int i = 1; i < 12; i++) b[i] = 32'h8000_0000;
		send(b);
		b[0] = 12'd5;
		for (int i = 1; i < 12; i++) b[i] = 32'h0010_0000;
		send(b);
		v = b; v[1] = v[1] + 10; send(v);
		v = b; v[1] = v[1] + 11; send(v);
		v = b; v[5] = v[5] - 32'd65536; send(v);
		v = b; v[7] = 32'hffff_ffff; v[9] = 32'h8000_0000; send(v);
		drain();
		write_reg(CFG_COLORS, 32'd1);
		write_reg(CFG_UV_LAYERS, 32'd3);
		b[0] = 12'd7;
		send(b);
		v = b; v[7] = v[7] ^ 32'h1; send(v);
		v = b; v[11] = v[11] + 3; send(v);
		v = b; v[11] = v[11] + 300; send(v);
		drain();
		write_reg(CFG_TOL, 32'd0);
		send(b);
		drain();
		write_reg(CFG_TOL, 32'hffff_ffff);
		v = b; v[2] = v[2] + 32'd65535; send(v);
		v = b; v[2] = v[2] - 32'd100; send(v);
		drain();

		// random, sender mostly busy and receiver slow
		write_reg(CFG_UV_LAYERS, 32'd2);
		write_reg(CFG_COLORS, 32'd1);
		write_reg(CFG_TOL, $urandom_range(20, 400));
		for (int n = 0; n < 500; n++) send(random_vtx());
		drain();

		// random, roles swapped, with a full pause halfway
		send_idle_pct = 72;
		recv_idle_pct = 26;
		write_reg(CFG_UV_LAYERS, 32'd1);
		write_reg(CFG_COLORS, 32'd0);
		write_reg(CFG_TOL, 32'hffff_ffff);
		for (int n = 0; n < 250; n++) send(random_vtx());
		drain();
		for (int n = 0; n < 250; n++) send(random_vtx());
		drain();

		// random, no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_UV_LAYERS, 32'd0);
		write_reg(CFG_COLORS, 32'd1);
		write_reg(CFG_TOL, 32'd110);
		for (int n = 0; n < 550; n++) send(random_vtx());
		drain();

		$display("checked %0d words: %0d appended, %0d welded to an old slot, %0d overflowed",
			checked, n_new, n_reuse, n_ovf);
		$display("%0d mismatches", errors);
		if (errors == 0 && expected_welds.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#9_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
